// File: rtl/bsgi_pkg.sv
// shared constants and types of the bayer split / green interpolation block
`timescale 1ns / 1ps
package bsgi_pkg;

	// field widths of the channels
	localparam int PIXEL_W     = 8;
	localparam int COORD_W     = 11;
	localparam int PLANE_W     = 2;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 11;

	// target plane codes
	localparam logic [PLANE_W-1:0] PLANE_RED   = 2'd0;
	localparam logic [PLANE_W-1:0] PLANE_GREEN = 2'd1;
	localparam logic [PLANE_W-1:0] PLANE_BLUE  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_HEIGHT = 4'd1;

	// size limits and reset size of the red/blue plane
	localparam int MIN_SIZE   = 3;
	localparam int SIZE_RESET = 1024;

	// number of line buffers, one per bayer row held
	localparam int NUM_LINES = 3;

	// order of the six results of one cell
	typedef enum logic [2:0] {
		RES_RED    = 3'd0,
		RES_BLUE   = 3'd1,
		RES_G_TOP  = 3'd2,
		RES_G_LEFT = 3'd3,
		RES_G_MID  = 3'd4,
		RES_G_DIAG = 3'd5
	} res_idx_t;

endpackage

// File: rtl/bsgi_if.sv
// valid/ready channel interfaces: pixel input, result output, configuration write
`timescale 1ns / 1ps
interface bsgi_pix_if;
	import bsgi_pkg::*;
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;
	logic               frame_start;
	modport source (output valid, pixel, frame_start, input ready);
	modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface bsgi_res_if;
	import bsgi_pkg::*;
	logic               valid;
	logic               ready;
	logic [PLANE_W-1:0] plane;
	logic [COORD_W-1:0] out_col;
	logic [COORD_W-1:0] out_row;
	logic [PIXEL_W-1:0] value;
	logic               last;
	modport source (output valid, plane, out_col, out_row, value, last, input ready);
	modport sink (input valid, plane, out_col, out_row, value, last, output ready);
endinterface

interface bsgi_cfg_if;
	import bsgi_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/bsgi_ram.sv
// generic single write port ram with registered read-first output
`timescale 1ns / 1ps
module bsgi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word when the same address is written
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// File: rtl/bayer_split_green_interp_core.sv
// top level: rggb bayer splitter with bilinear green fill
//
// channel  dir  handshake    payload
// pix      in   valid/ready  pixel, frame_start
// res      out  valid/ready  plane, out_col, out_row, value, last
// cfg      in   valid/ready  index, data (ready always high)
//
// A pixel that completes no cell is taken every cycle unless the input stage is held.
// A pixel that completes an interior cell loads six results into the result register,
// which sends one per cycle while res.ready is high; the next such pixel waits in the
// input stage until the sixth is taken. A pixel passes the input stage and then the
// result register before its first result is offered.
// Reset clears counters and sets the half sizes to 1024; line buffers are not cleared.
// A stalled result side holds the result register and then the input stage.
`timescale 1ns / 1ps
module bayer_split_green_interp_core #(
	parameter int MAX_HALF_WIDTH  = 1024,
	parameter int MAX_HALF_HEIGHT = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	bsgi_pix_if.sink   pix,
	bsgi_res_if.source res,
	bsgi_cfg_if.sink   cfg
);

	import bsgi_pkg::*;

	localparam int ROW_LEN = 2 * MAX_HALF_WIDTH;
	localparam int CW      = $clog2(ROW_LEN);
	localparam int WW      = CW + 1;
	localparam int RW      = $clog2(2 * MAX_HALF_HEIGHT);
	localparam int HW      = RW + 1;
	localparam int RST_HALF_W = (SIZE_RESET > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : SIZE_RESET;
	localparam int RST_HALF_H = (SIZE_RESET > MAX_HALF_HEIGHT) ? MAX_HALF_HEIGHT : SIZE_RESET;
	localparam logic [WW-1:0] RST_WID = WW'(2 * RST_HALF_W);
	localparam logic [HW-1:0] RST_HGT = HW'(2 * RST_HALF_H);

	// configuration: bayer row length and frame height, clamped on write
	logic [WW-1:0] wid_q;
	logic [HW-1:0] hgt_q;
	logic [CW-1:0] hw_cl;
	logic [RW-1:0] hh_cl;

	// position counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [1:0]    slot_q;

	// position of the item being taken
	logic          accept;
	logic [CW-1:0] c_a, c_b, c_ahead;
	logic [RW-1:0] r_a, r_c;
	logic [HW-1:0] r_b, r_d;
	logic [1:0]    s_a, s_b, s_c;
	logic [WW-1:0] c_n;
	logic          emit;
	logic [CW-1:0] col_d;
	logic [RW-1:0] row_d;
	logic [1:0]    slot_d;

	// line buffers
	logic [PIXEL_W-1:0] rd_data [NUM_LINES];

	// stage 1
	logic               valid_s1;
	logic               emit_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	logic [CW-1:0]      col_s1;
	logic [RW-1:0]      row_s1;
	logic [1:0]         slot_s1;
	logic               adv_s1;
	logic [PIXEL_W-1:0] up, prev, prev2;

	// neighbourhood history
	logic [PIXEL_W-1:0] h2_q [3];
	logic [PIXEL_W-1:0] h1_q [2];
	logic [PIXEL_W-1:0] tap_q;
	logic [PIXEL_W+1:0] sum_mid, sum_diag;

	// result register
	logic               res_valid_q;
	res_idx_t           idx_q;
	logic [PIXEL_W-1:0] val_q [6];
	logic [CW-1:0]      res_c_q;
	logic [RW-1:0]      res_r_q;
	logic               buf_free;
	logic               res_take;

	// clamped sizes from the write data
	always_comb begin
		if (cfg.data < CFG_DATA_W'(MIN_SIZE)) begin
			hw_cl = CW'(MIN_SIZE);
			hh_cl = RW'(MIN_SIZE);
		end else begin
			hw_cl = (cfg.data > MAX_HALF_WIDTH) ? CW'(MAX_HALF_WIDTH) : CW'(cfg.data);
			hh_cl = (cfg.data > MAX_HALF_HEIGHT) ? RW'(MAX_HALF_HEIGHT) : RW'(cfg.data);
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wid_q <= RST_WID;
			hgt_q <= RST_HGT;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HALF_WIDTH:  wid_q <= {hw_cl, 1'b0};
				REG_HALF_HEIGHT: hgt_q <= {hh_cl, 1'b0};
				default: ;
			endcase
		end
	end

	// place the item, then step the counters past it
	assign accept = pix.valid && pix.ready;

	always_comb begin
		c_a = pix.frame_start ? '0 : col_q;
		r_a = pix.frame_start ? '0 : row_q;
		s_a = pix.frame_start ? 2'd0 : slot_q;
		// column beyond a shrunk row length moves to the next row
		if ({1'b0, c_a} >= wid_q) begin
			c_b = '0;
			r_b = {1'b0, r_a} + HW'(1);
			s_b = (s_a == 2'(NUM_LINES - 1)) ? 2'd0 : s_a + 2'd1;
		end else begin
			c_b = c_a;
			r_b = {1'b0, r_a};
			s_b = s_a;
		end
		if (r_b >= hgt_q) begin
			r_c = '0;
			s_c = 2'd0;
		end else begin
			r_c = r_b[RW-1:0];
			s_c = s_b;
		end
		// next position
		c_n = {1'b0, c_b} + WW'(1);
		r_d = {1'b0, r_c} + HW'(1);
		if (c_n >= wid_q) begin
			col_d = '0;
			if (r_d >= hgt_q) begin
				row_d  = '0;
				slot_d = 2'd0;
			end else begin
				row_d  = r_d[RW-1:0];
				slot_d = (s_c == 2'(NUM_LINES - 1)) ? 2'd0 : s_c + 2'd1;
			end
		end else begin
			col_d  = c_n[CW-1:0];
			row_d  = r_c;
			slot_d = s_c;
		end
		// interior cell completes at an odd column of an even row
		emit = !r_c[0] && (r_c >= RW'(4)) && (r_d + HW'(1) <= hgt_q)
			&& c_b[0] && (c_b >= CW'(3)) && (c_n + WW'(2) <= wid_q);
		// look-ahead column for the two older rows
		c_ahead = (c_b == CW'(ROW_LEN - 1)) ? '0 : c_b + CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= 2'd0;
		end else if (accept) begin
			col_q  <= col_d;
			row_q  <= row_d;
			slot_q <= slot_d;
		end
	end

	// three line buffers: current slot read at the column, older rows one ahead
	for (genvar g = 0; g < NUM_LINES; g++) begin : g_line
		bsgi_ram #(
			.WIDTH(PIXEL_W),
			.DEPTH(ROW_LEN)
		) u_line (
			.clk  (clk),
			.we   (accept && (s_c == 2'(g))),
			.waddr(c_b),
			.wdata(pix.pixel),
			.re   (accept),
			.raddr((s_c == 2'(g)) ? c_b : c_ahead),
			.rdata(rd_data[g])
		);
	end

	// stage 1 control
	assign buf_free = !res_valid_q || (res.ready && idx_q == RES_G_DIAG);
	assign adv_s1   = valid_s1 && (!emit_s1 || buf_free);
	assign pix.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1  <= emit;
			pixel_s1 <= pix.pixel;
			col_s1   <= c_b;
			row_s1   <= r_c;
			slot_s1  <= s_c;
		end
	end

	// sort buffer outputs into rows r-3, r-1 and r-2
	always_comb begin
		case (slot_s1)
			2'd0: begin
				up    = rd_data[0];
				prev  = rd_data[2];
				prev2 = rd_data[1];
			end
			2'd1: begin
				up    = rd_data[1];
				prev  = rd_data[0];
				prev2 = rd_data[2];
			end
			default: begin
				up    = rd_data[2];
				prev  = rd_data[1];
				prev2 = rd_data[0];
			end
		endcase
	end

	// history of the two older rows and the row three up
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			h2_q[0] <= prev2;
			h2_q[1] <= h2_q[0];
			h2_q[2] <= h2_q[1];
			h1_q[0] <= prev;
			h1_q[1] <= h1_q[0];
			tap_q   <= up;
		end
	end

	// four-neighbour sums with rounding
	assign sum_mid = 10'd2 + {2'b00, h2_q[0]} + {2'b00, h2_q[2]} + {2'b00, h1_q[1]}
		+ {2'b00, tap_q};
	assign sum_diag = 10'd2 + {2'b00, h2_q[0]} + {2'b00, h1_q[1]} + {2'b00, prev}
		+ {2'b00, pixel_s1};

	// result register load and drain
	assign res_take = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q       <= RES_RED;
		end else if (adv_s1 && emit_s1) begin
			res_valid_q <= 1'b1;
			idx_q       <= RES_RED;
		end else if (res_take) begin
			if (idx_q == RES_G_DIAG) begin
				res_valid_q <= 1'b0;
				idx_q       <= RES_RED;
			end else begin
				idx_q <= res_idx_t'(idx_q + 3'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			val_q[0] <= h2_q[1];
			val_q[1] <= h1_q[0];
			val_q[2] <= h2_q[0];
			val_q[3] <= h1_q[1];
			val_q[4] <= sum_mid[PIXEL_W+1:2];
			val_q[5] <= sum_diag[PIXEL_W+1:2];
			res_c_q  <= col_s1;
			res_r_q  <= row_s1;
		end
	end

	// result fields for the current position in the cell
	assign res.valid = res_valid_q;

	always_comb begin
		res.last = 1'b0;
		case (idx_q)
			RES_RED: begin
				res.plane   = PLANE_RED;
				res.out_col = COORD_W'(res_c_q >> 1);
				res.out_row = COORD_W'((res_r_q >> 1) - RW'(1));
				res.value   = val_q[0];
			end
			RES_BLUE: begin
				res.plane   = PLANE_BLUE;
				res.out_col = COORD_W'(res_c_q >> 1);
				res.out_row = COORD_W'((res_r_q >> 1) - RW'(1));
				res.value   = val_q[1];
			end
			RES_G_TOP: begin
				res.plane   = PLANE_GREEN;
				res.out_col = COORD_W'(res_c_q);
				res.out_row = COORD_W'(res_r_q - RW'(2));
				res.value   = val_q[2];
			end
			RES_G_LEFT: begin
				res.plane   = PLANE_GREEN;
				res.out_col = COORD_W'(res_c_q - CW'(1));
				res.out_row = COORD_W'(res_r_q - RW'(1));
				res.value   = val_q[3];
			end
			RES_G_MID: begin
				res.plane   = PLANE_GREEN;
				res.out_col = COORD_W'(res_c_q - CW'(1));
				res.out_row = COORD_W'(res_r_q - RW'(2));
				res.value   = val_q[4];
			end
			RES_G_DIAG: begin
				res.plane   = PLANE_GREEN;
				res.out_col = COORD_W'(res_c_q);
				res.out_row = COORD_W'(res_r_q - RW'(1));
				res.value   = val_q[5];
				res.last    = 1'b1;
			end
			default: begin
				res.plane   = PLANE_GREEN;
				res.out_col = '0;
				res.out_row = '0;
				res.value   = '0;
			end
		endcase
	end

endmodule
